// ----- src/crc32w_pkg.sv -----
// ----------------------------------------------------------------------------
// crc32w_pkg
// Shared types and constants for the CRC-32 word stream core.
// ----------------------------------------------------------------------------
package crc32w_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned WordWidth = 32;

  localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] CrcPoly = 32'h04C1_1DB7;
  localparam logic [CrcWidth-1:0] CrcTop  = 32'h8000_0000;

  // One input item as held in the input register
  typedef struct packed {
    logic [WordWidth-1:0] word;
    logic                 first;
    logic                 last;
  } crc32w_item_t;

  // Per-output-bit XOR masks: row i lists the inputs that feed CRC bit i
  typedef logic [CrcWidth-1:0][CrcWidth-1:0] crc32w_mat_t;

  // Bit-serial word update, MSB first; evaluated at elaboration only
  function automatic logic [CrcWidth-1:0] crc32w_serial(
    input logic [CrcWidth-1:0]  crc_in,
    input logic [WordWidth-1:0] word
  );
    logic [CrcWidth-1:0] crc;
    logic                top;
    crc = crc_in;
    for (int n = 0; n < WordWidth; n++) begin
      top = crc[CrcWidth-1];
      crc = {crc[CrcWidth-2:0], 1'b0};
      if (top) crc = crc ^ CrcPoly;
      if (word[WordWidth-1-n]) crc = crc ^ CrcPoly;
    end
    return crc;
  endfunction

  // Build the mask matrix from single-bit responses of the register or word
  function automatic crc32w_mat_t crc32w_matrix(input logic from_word);
    crc32w_mat_t         m;
    logic [CrcWidth-1:0] resp;
    m = '0;
    for (int j = 0; j < CrcWidth; j++) begin
      if (from_word) begin
        resp = crc32w_serial('0, WordWidth'(1) << j);
      end else begin
        resp = crc32w_serial(CrcWidth'(1) << j, '0);
      end
      for (int i = 0; i < CrcWidth; i++) begin
        m[i][j] = resp[i];
      end
    end
    return m;
  endfunction

  localparam crc32w_mat_t CrcMatState = crc32w_matrix(1'b0);
  localparam crc32w_mat_t CrcMatWord  = crc32w_matrix(1'b1);

endpackage

// ----- src/crc32w_in_stage.sv -----
// ----------------------------------------------------------------------------
// crc32w_in_stage
// Input register: captures one transaction and holds it until consumed.
// ----------------------------------------------------------------------------
module crc32w_in_stage import crc32w_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  crc32w_item_t in_item_i,
  output logic         stg_valid_o,
  input  logic         stg_take_i,
  output crc32w_item_t stg_item_o
);

  logic         valid_q, valid_d;
  crc32w_item_t item_q;

  // Accept when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || stg_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= in_item_i;
  end

  assign stg_valid_o = valid_q;
  assign stg_item_o  = item_q;

endmodule

// ----- src/crc32w_next.sv -----
// ----------------------------------------------------------------------------
// crc32w_next
// One-word CRC update as a flat XOR network over register and data bits.
// ----------------------------------------------------------------------------
module crc32w_next import crc32w_pkg::*; (
  input  logic [CrcWidth-1:0]  crc_i,
  input  logic [WordWidth-1:0] word_i,
  output logic [CrcWidth-1:0]  crc_o
);

  // Each output bit is the parity of its masked register and word bits
  always_comb begin
    for (int i = 0; i < CrcWidth; i++) begin
      crc_o[i] = ^(crc_i & CrcMatState[i]) ^ ^(word_i & CrcMatWord[i]);
    end
  end

endmodule

// ----- src/crc32_word_stream_core.sv -----
// ----------------------------------------------------------------------------
// crc32_word_stream_core
// CRC-32 (poly 0x04C11DB7, init all ones, no reflection, no final XOR)
// over a stream of 32-bit words, one word per cycle while the output flows.
// ----------------------------------------------------------------------------
// The input register holds a last word, then the result register its CRC.
// Throughput: 1 word per cycle; the XOR network updates the CRC register,
// so words flow while the result drains, but a last word waits until it is taken.
// Reset: asynchronous, active low; clears valid flags and loads the CRC
// register with all ones.
module crc32_word_stream_core import crc32w_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [WordWidth-1:0] s_axis_tdata_i,   // [31:0] data_word
  input  logic                 s_axis_tuser_i,   // [0] first_word
  input  logic                 s_axis_tlast_i,   // last_word
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [CrcWidth-1:0]  m_axis_tdata_o    // [31:0] crc_value
);

  crc32w_item_t        in_item, stg_item;
  logic                stg_valid, stg_take;
  logic [CrcWidth-1:0] crc_q, crc_d, crc_start, crc_next;
  logic                out_valid_q, out_valid_d;
  logic [CrcWidth-1:0] out_data_q;

  assign in_item = '{word: s_axis_tdata_i, first: s_axis_tuser_i, last: s_axis_tlast_i};

  crc32w_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .stg_valid_o (stg_valid),
    .stg_take_i  (stg_take),
    .stg_item_o  (stg_item)
  );

  // Consume a held word unless it is last and the result slot is blocked
  assign stg_take = stg_valid && (!stg_item.last || !out_valid_q || m_axis_tready_i);

  // Reload on a first word, then fold in the data
  assign crc_start = stg_item.first ? CrcInit : crc_q;

  crc32w_next u_next (
    .crc_i  (crc_start),
    .word_i (stg_item.word),
    .crc_o  (crc_next)
  );

  // Advance the running CRC; restart after a last word
  always_comb begin
    crc_d = crc_q;
    if (stg_take) crc_d = stg_item.last ? CrcInit : crc_next;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    if (stg_take && stg_item.last) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result until the master side takes it
  always_ff @(posedge clk_i) begin
    if (stg_take && stg_item.last) out_data_q <= crc_next;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // A last word always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_take && stg_item.last |=> out_valid_q)
    else $error("last word consumed without a result");

  // The register restarts from all ones after a message ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_take && stg_item.last |=> crc_q == CrcInit)
    else $error("CRC register not reloaded after last word");

  // A stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q))
    else $error("pending result lost or changed");

  // Input stalls only while a word is held and blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> stg_valid && stg_item.last && out_valid_q)
    else $error("input stalled without cause");
`endif

endmodule
